/* rtl/core/pld_pkg.sv */
// shared types and constants for the polyline length and derivative block
package pld_pkg;

	// fraction bits of the fixed point format; the datapath keeps the input scale
	localparam int unsigned FracBits = 16;
	localparam int unsigned LenW = 40;
	localparam int unsigned CoordW = 32;
	localparam logic [LenW-1:0] LenMax = {LenW{1'b1}};
	localparam logic signed [LenW-1:0] SlopeMax = {1'b0, {(LenW-1){1'b1}}};
	localparam logic signed [LenW-1:0] SlopeMin = {1'b1, {(LenW-1){1'b0}}};

	// one input point
	typedef struct packed {
		logic signed [CoordW-1:0] pos_x;
		logic signed [CoordW-1:0] pos_y;
		logic signed [CoordW-1:0] pos_z;
		logic signed [CoordW-1:0] grad_x;
		logic signed [CoordW-1:0] grad_y;
		logic signed [CoordW-1:0] grad_z;
		logic depends;
		logic final_point;
	} pld_in_t;

	// one result
	typedef struct packed {
		logic [LenW-1:0] total_length;
		logic signed [LenW-1:0] length_slope;
		logic degenerate;
	} pld_out_t;

	// segment job handed from front to back
	typedef struct packed {
		logic signed [2:0][32:0] dp;
		logic signed [2:0][32:0] dg;
		logic has_seg;
		logic dep;
		logic fin;
	} pld_job_t;

endpackage

/* rtl/core/pld_front.sv */
// front end: keeps the previous point and forms segment differences
module pld_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  pld_pkg::pld_in_t in_data,
	output logic job_valid,
	input  logic job_stall,
	output pld_pkg::pld_job_t job_data
);
	import pld_pkg::*;

	logic signed [2:0][CoordW-1:0] prev_pos_q, prev_grad_q, cur_pos, cur_grad;
	logic prev_dep_q, have_prev_q;
	logic job_valid_q;
	pld_job_t job_q, job_d;
	logic take;

	assign cur_pos = {in_data.pos_z, in_data.pos_y, in_data.pos_x};
	assign cur_grad = {in_data.grad_z, in_data.grad_y, in_data.grad_x};
	assign in_stall = job_valid_q && job_stall;
	assign take = in_valid && !in_stall;

	// differences prev - cur, exact in 33 bits
	always_comb begin
		job_d = '0;
		for (int i = 0; i < 3; i++) begin
			job_d.dp[i] = {prev_pos_q[i][CoordW-1], prev_pos_q[i]}
				- {cur_pos[i][CoordW-1], cur_pos[i]};
			job_d.dg[i] = {prev_grad_q[i][CoordW-1], prev_grad_q[i]}
				- {cur_grad[i][CoordW-1], cur_grad[i]};
		end
		job_d.has_seg = have_prev_q;
		job_d.dep = prev_dep_q || in_data.depends;
		job_d.fin = in_data.final_point;
	end

	// previous point state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pos_q <= '0;
			prev_grad_q <= '0;
			prev_dep_q <= 1'b0;
			have_prev_q <= 1'b0;
		end else if (take) begin
			if (in_data.final_point) begin
				prev_pos_q <= '0;
				prev_grad_q <= '0;
				prev_dep_q <= 1'b0;
				have_prev_q <= 1'b0;
			end else begin
				prev_pos_q <= cur_pos;
				prev_grad_q <= cur_grad;
				prev_dep_q <= in_data.depends;
				have_prev_q <= 1'b1;
			end
		end
	end

	// one-entry job queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
		end else if (take) begin
			job_valid_q <= 1'b1;
		end else if (!job_stall) begin
			job_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			job_q <= job_d;
		end
	end

	assign job_valid = job_valid_q;
	assign job_data = job_q;
endmodule

/* rtl/core/pld_back.sv */
// back end: squares, sqrt, divide and saturating accumulation
module pld_back (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	output logic job_stall,
	input  pld_pkg::pld_job_t job_data,
	output logic out_valid,
	input  logic out_stall,
	output pld_pkg::pld_out_t out_data
);
	import pld_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL  = 6'b000010,
		ST_SQRT = 6'b000100,
		ST_DIV  = 6'b001000,
		ST_ACC  = 6'b010000,
		ST_OUT  = 6'b100000
	} st_t;

	st_t st_q;
	pld_job_t job_q;
	logic [1:0] idx_q;
	logic [6:0] cnt_q;
	logic [67:0] sq_q;
	logic signed [68:0] dot_q;
	logic [65:0] mul_sq, mul_dg_mag;
	logic [32:0] va, ga;
	logic [34:0] root_q;
	logic [71:0] rem_q;
	logic [67:0] rad_q;
	logic [67:0] num_q;
	logic [35:0] drem_q;
	logic [68:0] quo_q;
	logic neg_q;
	logic [LenW-1:0] len_acc_q;
	logic signed [LenW-1:0] slope_acc_q;
	logic deg_q;
	logic out_valid_q;
	pld_out_t out_q;
	logic [71:0] trial;
	logic [35:0] dtrial;
	logic [41:0] len_sum;
	logic [68:0] quo_rnd;
	logic signed [LenW+1:0] slope_sum;
	logic [LenW:0] qcap;
	logic [34:0] len_r;
	logic out_load;

	assign job_stall = (st_q != ST_IDLE);
	assign va = job_q.dp[idx_q][32] ? -job_q.dp[idx_q] : job_q.dp[idx_q];
	assign ga = job_q.dg[idx_q][32] ? -job_q.dg[idx_q] : job_q.dg[idx_q];
	assign mul_sq = va * va;
	assign mul_dg_mag = va * ga;
	assign trial = {rem_q[69:0], rad_q[67:66]} - {35'd0, root_q, 2'b01};
	assign len_r = root_q + 35'((rem_q > 72'(root_q)) ? 1 : 0);
	assign dtrial = {drem_q[34:0], num_q[67]} - {1'b0, len_r};

	// length total candidate
	assign len_sum = {7'd0, len_r} + {2'd0, len_acc_q};

	// quotient rounding, cap and slope total candidate
	assign quo_rnd = quo_q + {68'd0, ({drem_q, 1'b0} >= {1'b0, len_r})};
	assign qcap = (quo_rnd > (69'd1 << LenW)) ? (41'd1 << LenW) : quo_rnd[LenW:0];
	assign slope_sum = neg_q ? 42'(slope_acc_q) - 42'(qcap)
		: 42'(slope_acc_q) + 42'(qcap);

	// result register load
	assign out_load = (st_q == ST_OUT) && (idx_q != 2'd3) && job_q.fin
		&& (!out_valid_q || !out_stall);

	// sequencer: one product term, one root bit or one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			len_acc_q <= '0;
			slope_acc_q <= '0;
			deg_q <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (job_valid) begin
						job_q <= job_data;
						idx_q <= '0;
						sq_q <= '0;
						dot_q <= '0;
						st_q <= job_data.has_seg ? ST_MUL : ST_OUT;
					end
				end
				ST_MUL: begin
					sq_q <= sq_q + 68'(mul_sq);
					if (job_q.dp[idx_q][32] ^ job_q.dg[idx_q][32])
						dot_q <= dot_q - 69'(mul_dg_mag);
					else
						dot_q <= dot_q + 69'(mul_dg_mag);
					if (idx_q == 2'd2) begin
						st_q <= ST_SQRT;
						cnt_q <= '0;
						root_q <= '0;
						rem_q <= '0;
						rad_q <= sq_q + 68'(mul_sq);
					end else begin
						idx_q <= idx_q + 2'd1;
					end
				end
				ST_SQRT: begin
					rad_q <= {rad_q[65:0], 2'b00};
					if (!trial[71]) begin
						rem_q <= trial;
						root_q <= {root_q[33:0], 1'b1};
					end else begin
						rem_q <= {rem_q[69:0], rad_q[67:66]};
						root_q <= {root_q[33:0], 1'b0};
					end
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd33) st_q <= ST_ACC;
				end
				ST_ACC: begin
					len_acc_q <= (len_sum > {2'd0, LenMax}) ? LenMax : len_sum[LenW-1:0];
					root_q <= len_r;
					if (!job_q.dep) begin
						st_q <= ST_OUT;
					end else if (len_r == '0) begin
						deg_q <= 1'b1;
						st_q <= ST_OUT;
					end else begin
						neg_q <= dot_q[68];
						num_q <= dot_q[68] ? 68'(-dot_q) : dot_q[67:0];
						rem_q <= '0;
						drem_q <= '0;
						quo_q <= '0;
						cnt_q <= '0;
						st_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					num_q <= {num_q[66:0], 1'b0};
					if (!dtrial[35]) begin
						drem_q <= dtrial;
						quo_q <= {quo_q[67:0], 1'b1};
					end else begin
						drem_q <= {drem_q[34:0], num_q[67]};
						quo_q <= {quo_q[67:0], 1'b0};
					end
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd67) begin
						st_q <= ST_OUT;
						idx_q <= 2'd3;
					end
				end
				ST_OUT: begin
					if (idx_q == 2'd3) begin
						// finish rounding and add quotient
						idx_q <= '0;
						if (slope_sum > 42'(SlopeMax)) slope_acc_q <= SlopeMax;
						else if (slope_sum < 42'(SlopeMin)) slope_acc_q <= SlopeMin;
						else slope_acc_q <= slope_sum[LenW-1:0];
					end else if (!job_q.fin) begin
						st_q <= ST_IDLE;
					end else if (out_load) begin
						out_q.total_length <= len_acc_q;
						out_q.length_slope <= slope_acc_q;
						out_q.degenerate <= deg_q;
						len_acc_q <= '0;
						slope_acc_q <= '0;
						deg_q <= 1'b0;
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;
endmodule

/* rtl/core/polyline_length_and_derivative.sv */
// The back end works on one segment at a time: a bit-serial sqrt (34 steps) forms its length and,
// when it also adds a slope term, a bit-serial divide (68 steps) forms the quotient; the one-entry
// job queue lets the front take the next point while the back works. A result waits on out_stall.
// Reset: arst_n clears the previous point, both totals and the degenerate flag.
// top level: polyline arc length and slope accumulator
module polyline_length_and_derivative (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  pld_pkg::pld_in_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output pld_pkg::pld_out_t out_data
);
	import pld_pkg::*;

	logic job_valid, job_stall;
	pld_job_t job_data;

	pld_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.job_valid(job_valid), .job_stall(job_stall), .job_data(job_data)
	);

	pld_back u_back (
		.clk(clk), .arst_n(arst_n),
		.job_valid(job_valid), .job_stall(job_stall), .job_data(job_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);
endmodule

/* rtl/core/pld_checker.sv */
// port-level checks for the polyline length block, bound to the top level
module pld_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input pld_pkg::pld_out_t out_data
);
	import pld_pkg::*;

	// result held while stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed under stall");

	// stalled input transaction stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid)
		else $error("input transaction withdrawn under stall");

	// no result rises in the first cycle out of reset
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(arst_n))
		else $error("result right after reset");

	// result register empty out of reset
	assert property (@(posedge clk) $rose(arst_n) |-> !out_valid)
		else $error("result valid out of reset");
endmodule

bind polyline_length_and_derivative pld_checker u_pld_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

/* bench/tb_polyline_length_and_derivative.sv */
// testbench for the polyline arc length and slope accumulator
`timescale 1ns / 100ps

module tb_polyline_length_and_derivative;
	import pld_pkg::*;

	localparam int unsigned WatchdogLimit = 20000;
	localparam int unsigned SettleCycles = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	pld_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	pld_out_t out_data;

	// predictor state
	logic signed [CoordW-1:0] last_pos [3];
	logic signed [CoordW-1:0] last_grad [3];
	logic last_dep;
	logic seg_open;
	logic [LenW-1:0] len_sum;
	logic signed [LenW-1:0] slope_sum;
	logic zero_seen;

	pld_out_t totals_q [$];
	int unsigned mismatches = 0;
	int unsigned idle_cycles = 0;
	int unsigned out_hold = 0;
	bit out_drawn = 1'b0;

	polyline_length_and_derivative DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	// clock
	always #1 clk = ~clk;

	// square root of a 68 bit value, rounded half up
	function automatic logic [35:0] seg_sqrt(input logic [67:0] sq);
		logic [35:0] lo;
		logic [35:0] hi;
		logic [35:0] mid;
		lo = '0;
		hi = 36'((64'd1 << 34) - 1);
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			if (72'(mid) * 72'(mid) <= 72'(sq)) lo = mid;
			else hi = mid - 1;
		end
		if (72'(sq) - 72'(lo) * 72'(lo) > 72'(lo)) lo = lo + 1;
		return lo;
	endfunction

	task automatic clear_predictor();
		last_pos = '{default: '0};
		last_grad = '{default: '0};
		last_dep = 1'b0;
		seg_open = 1'b0;
		len_sum = '0;
		slope_sum = '0;
		zero_seen = 1'b0;
	endtask

	// predict one accepted point
	task automatic predict_point(input pld_in_t p);
		logic signed [67:0] sq;
		logic signed [67:0] dot;
		logic signed [32:0] dpos;
		logic signed [32:0] dgrad;
		logic signed [CoordW-1:0] pos [3];
		logic signed [CoordW-1:0] grad [3];
		logic [35:0] len;
		logic [67:0] mag;
		logic [67:0] quo;
		logic [67:0] rem;
		logic signed [42:0] acc;
		pld_out_t res;
		pos = '{p.pos_x, p.pos_y, p.pos_z};
		grad = '{p.grad_x, p.grad_y, p.grad_z};
		if (seg_open) begin
			sq = '0;
			dot = '0;
			for (int i = 0; i < 3; i++) begin
				dpos = 33'(last_pos[i]) - 33'(pos[i]);
				dgrad = 33'(last_grad[i]) - 33'(grad[i]);
				sq += 68'(dpos) * 68'(dpos);
				dot += 68'(dpos) * 68'(dgrad);
			end
			len = seg_sqrt(sq);
			if (44'(len_sum) + 44'(len) > 44'(LenMax)) len_sum = LenMax;
			else len_sum = len_sum + LenW'(len);
			if (last_dep || p.depends) begin
				if (len == 0) zero_seen = 1'b1;
				else begin
					mag = dot < 0 ? 68'(-dot) : 68'(dot);
					quo = mag / 68'(len);
					rem = mag % 68'(len);
					if (2 * rem >= 68'(len)) quo = quo + 1;
					if (quo > (68'd1 << 40)) quo = 68'd1 << 40;
					acc = 43'(slope_sum) + (dot < 0 ? -43'(quo) : 43'(quo));
					if (acc > 43'(SlopeMax)) slope_sum = SlopeMax;
					else if (acc < 43'(SlopeMin)) slope_sum = SlopeMin;
					else slope_sum = LenW'(acc);
				end
			end
		end
		if (p.final_point) begin
			res.total_length = len_sum;
			res.length_slope = slope_sum;
			res.degenerate = zero_seen;
			totals_q.push_back(res);
			clear_predictor();
		end else begin
			last_pos = pos;
			last_grad = grad;
			last_dep = p.depends;
			seg_open = 1'b1;
		end
	endtask

	task automatic report_mismatch(input string what, input logic [LenW-1:0] got,
		input logic [LenW-1:0] want);
		$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
		mismatches++;
	endtask

	// send one point, random gap before it; valid stays up on return
	task automatic send_point(input pld_in_t p);
		int unsigned gap;
		gap = $urandom_range(0, 3);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data <= p;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		predict_point(p);
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_coord(input int unsigned span);
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'h8000_0000;
			2: return 32'h7fff_ffff;
			default: return 32'(signed'($urandom_range(0, 2 * span)) - signed'(span));
		endcase
	endfunction

	function automatic pld_in_t make_point(input int unsigned span, input bit dep, input bit fin);
		pld_in_t p;
		p.pos_x = rand_coord(span);
		p.pos_y = rand_coord(span);
		p.pos_z = rand_coord(span);
		p.grad_x = rand_coord(span);
		p.grad_y = rand_coord(span);
		p.grad_z = rand_coord(span);
		p.depends = dep;
		p.final_point = fin;
		return p;
	endfunction

	// result checking
	always @(posedge clk) begin
		pld_out_t want;
		if (in_valid && !in_stall || out_valid && !out_stall) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (out_valid && !out_stall) begin
			if (totals_q.size() == 0) begin
				report_mismatch("unexpected transaction", out_data.total_length, '0);
			end else begin
				want = totals_q.pop_front();
				if (out_data.total_length !== want.total_length)
					report_mismatch("total_length", out_data.total_length, want.total_length);
				if (out_data.length_slope !== want.length_slope)
					report_mismatch("length_slope", out_data.length_slope, want.length_slope);
				if (out_data.degenerate !== want.degenerate)
					report_mismatch("degenerate", LenW'(out_data.degenerate),
						LenW'(want.degenerate));
			end
		end
	end

	// output stall: a random wait is drawn for each result
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_drawn = 1'b0;
		end else if (out_valid) begin
			if (!out_drawn) begin
				out_hold = $urandom_range(0, 3);
				out_drawn = 1'b1;
			end
			if (out_hold != 0) begin
				out_stall <= 1'b1;
				out_hold--;
			end else begin
				out_stall <= 1'b0;
				out_drawn = 1'b0;
			end
		end else begin
			out_stall <= 1'b0;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (idle_cycles >= WatchdogLimit) begin
			$display("polyline_length_and_derivative verification failed");
			$finish;
		end
	end

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (totals_q.size() != 0) @(negedge clk);
	endtask

	// directed: extremes, degenerate and single point cases
	task automatic test_directed();
		pld_in_t p;
		p = '0;
		p.final_point = 1'b1;
		send_point(p);                          // final on first point
		p = '0; p.depends = 1'b1;
		send_point(p);
		p.final_point = 1'b1;
		send_point(p);                          // zero length, dependent
		p = '0;
		send_point(p);
		p.final_point = 1'b1;
		send_point(p);                          // zero length, no dependence
		p = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0};
		send_point(p);
		p = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0, 1'b0};
		send_point(p);
		p = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1, 1'b0};
		send_point(p);
		for (int i = 0; i < 160; i++) begin
			p.pos_x = ~p.pos_x; p.pos_y = ~p.pos_y; p.pos_z = ~p.pos_z;
			p.grad_x = ~p.grad_x; p.grad_y = ~p.grad_y; p.grad_z = ~p.grad_z;
			p.final_point = (i == 159);
			send_point(p);                      // drives both totals to saturation
		end
		p = make_point(65536, 1'b0, 1'b0);
		send_point(p);
		p.depends = 1'b0; p.final_point = 1'b1;
		send_point(p);                          // length only
	endtask

	// random polylines of 1 to 8 points, with small, random and extreme coordinates mixed
	task automatic test_random_polylines(input int unsigned points);
		int unsigned sent;
		int unsigned run;
		int unsigned span;
		sent = 0;
		while (sent < points) begin
			run = $urandom_range(1, 8);
			span = $urandom_range(0, 7) == 0 ? 32'h7fff_ffff : $urandom_range(1, 1 << 20);
			for (int unsigned k = 1; k <= run; k++) begin
				send_point(make_point(span, $urandom_range(0, 1), k == run));
				sent++;
			end
		end
	endtask

	// sender holds off until every result is out
	task automatic test_drain_pause();
		wait_drained();
		repeat (SettleCycles) @(negedge clk);
		test_random_polylines(20);
	endtask

	initial begin
		clear_predictor();
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random_polylines(380);
		test_drain_pause();
		test_random_polylines(390);
		wait_drained();
		repeat (SettleCycles) @(negedge clk);
		if (mismatches == 0) $display("polyline_length_and_derivative verification clean");
		else $display("polyline_length_and_derivative verification failed");
		$finish;
	end

endmodule
